// ===== hdl/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
`default_nettype none
package rhc_pkg;
    localparam int FIELD_BITS = 16;
    localparam int QUOT_BITS  = 17;
    localparam int HUE_SCALE  = 7680;   // 60 degrees in U9.7
    localparam logic [FIELD_BITS-1:0] DEG120 = 16'd15360;
    localparam logic [FIELD_BITS-1:0] DEG240 = 16'd30720;
    localparam logic [FIELD_BITS-1:0] DEG360 = 16'd46080;

    typedef enum logic [1:0] {
        HUE_RED,
        HUE_GREEN,
        HUE_BLUE
    } hue_case_t;

    typedef struct packed {
        logic                  grey;
        logic                  black;
        logic                  neg;
        hue_case_t             hcase;
        logic [FIELD_BITS-1:0] alpha;
    } side_t;
endpackage
`default_nettype wire

// ===== hdl/rhc_pixel_if.sv =====
// Input channel carrying one RGBA pixel.
`default_nettype none
interface rhc_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

// ===== hdl/rhc_hsv_if.sv =====
// Output channel carrying one HSV plus alpha pixel.
`default_nettype none
interface rhc_hsv_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] value;
    logic [15:0] alpha_out;
    modport source (output valid, hue, saturation, value, alpha_out, input ready);
    modport sink   (input valid, hue, saturation, value, alpha_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/rgb_to_hsv_convert.sv =====
// Top level of the pipelined RGB to HSV converter.
`default_nettype none
// Converts one RGBA pixel per clock into hue (U9.7 degrees), saturation (U0.16),
// value and alpha. The pipeline has 20 register stages: two for max/min and
// the scaled dividend, seventeen restoring division steps that produce the hue
// and saturation quotients side by side, one bit each, and the output register.
// A new pixel is taken every cycle; the whole pipeline holds while a finished
// result waits at the output. Channels are masked to CHANNEL_BITS significant
// bits.
module rgb_to_hsv_convert #(
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rhc_pixel_if.sink  pix_in,
    rhc_hsv_if.source  hsv_out
);
    localparam int W  = CHANNEL_BITS;
    localparam int QB = rhc_pkg::QUOT_BITS;

    logic en;

    logic                valid_s [QB+1];
    logic [W-1:0]        range_s [QB+1];
    logic [W-1:0]        mx_s    [QB+1];
    logic [W+16:0]       hrem_s  [QB+1];
    logic [W+16:0]       srem_s  [QB+1];
    logic [QB-1:0]       hq_s    [QB+1];
    logic [QB-1:0]       sq_s    [QB+1];
    rhc_pkg::side_t      side_s  [QB+1];

    // advance everything unless the output transaction is stalled
    assign en           = !hsv_out.valid || hsv_out.ready;
    assign pix_in.ready = en;

    rhc_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pix_in.valid),
        .red       (W'(pix_in.red)),
        .green     (W'(pix_in.green)),
        .blue      (W'(pix_in.blue)),
        .alpha     (pix_in.alpha),
        .valid_out (valid_s[0]),
        .range_out (range_s[0]),
        .mx_out    (mx_s[0]),
        .hue_rem   (hrem_s[0]),
        .sat_rem   (srem_s[0]),
        .side_out  (side_s[0])
    );

    assign hq_s[0] = '0;
    assign sq_s[0] = '0;

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        rhc_div_stage #(.W(W), .BIT(QB-1-i)) u_stage (
            .clk          (clk),
            .rst_n        (rst_n),
            .en           (en),
            .valid_in     (valid_s[i]),
            .range_in     (range_s[i]),
            .mx_in        (mx_s[i]),
            .hue_rem_in   (hrem_s[i]),
            .sat_rem_in   (srem_s[i]),
            .hue_quot_in  (hq_s[i]),
            .sat_quot_in  (sq_s[i]),
            .side_in      (side_s[i]),
            .valid_out    (valid_s[i+1]),
            .range_out    (range_s[i+1]),
            .mx_out       (mx_s[i+1]),
            .hue_rem_out  (hrem_s[i+1]),
            .sat_rem_out  (srem_s[i+1]),
            .hue_quot_out (hq_s[i+1]),
            .sat_quot_out (sq_s[i+1]),
            .side_out     (side_s[i+1])
        );
    end

    rhc_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid_in   (valid_s[QB]),
        .mx_in      (mx_s[QB]),
        .hue_quot   (hq_s[QB]),
        .sat_quot   (sq_s[QB]),
        .side_in    (side_s[QB]),
        .valid_out  (hsv_out.valid),
        .hue        (hsv_out.hue),
        .saturation (hsv_out.saturation),
        .value      (hsv_out.value),
        .alpha_out  (hsv_out.alpha_out)
    );
endmodule
`default_nettype wire

// ===== hdl/rhc_front.sv =====
// Front end: max/min selection, then range, difference and scaled dividend.
`default_nettype none
module rhc_front #(
    parameter int W = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  valid_in,
    input  wire logic [W-1:0]          red,
    input  wire logic [W-1:0]          green,
    input  wire logic [W-1:0]          blue,
    input  wire logic [15:0]           alpha,
    output logic                       valid_out,
    output logic [W-1:0]               range_out,
    output logic [W-1:0]               mx_out,
    output logic [W+16:0]              hue_rem,
    output logic [W+16:0]              sat_rem,
    output rhc_pkg::side_t             side_out
);
    localparam int DW = W + 17;

    logic [W-1:0] mx, mn, op_a, op_b;
    rhc_pkg::hue_case_t hcase;

    logic               a_valid_reg;
    logic [W-1:0]       a_mx_reg, a_mn_reg, a_opa_reg, a_opb_reg;
    rhc_pkg::hue_case_t a_case_reg;
    logic [15:0]        a_alpha_reg;

    logic [W-1:0] rng, diff;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        // red wins ties, then green
        if (mx == red)
        begin
            hcase = rhc_pkg::HUE_RED;
            op_a  = green;
            op_b  = blue;
        end
        else if (mx == green)
        begin
            hcase = rhc_pkg::HUE_GREEN;
            op_a  = blue;
            op_b  = red;
        end
        else
        begin
            hcase = rhc_pkg::HUE_BLUE;
            op_a  = red;
            op_b  = green;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            valid_out   <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid_in;
            valid_out   <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mx_reg    <= mx;
            a_mn_reg    <= mn;
            a_opa_reg   <= op_a;
            a_opb_reg   <= op_b;
            a_case_reg  <= hcase;
            a_alpha_reg <= alpha;
        end
    end

    assign rng  = a_mx_reg - a_mn_reg;
    assign diff = (a_opa_reg >= a_opb_reg) ? a_opa_reg - a_opb_reg : a_opb_reg - a_opa_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            range_out      <= rng;
            mx_out         <= a_mx_reg;
            // diff * 7680 as (diff << 13) - (diff << 9)
            hue_rem        <= (DW'(diff) << 13) - (DW'(diff) << 9);
            sat_rem        <= DW'(rng) << 16;
            side_out.grey  <= (rng == '0);
            side_out.black <= (a_mx_reg == '0);
            side_out.neg   <= (a_opa_reg < a_opb_reg);
            side_out.hcase <= a_case_reg;
            side_out.alpha <= a_alpha_reg;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/rhc_div_stage.sv =====
// One restoring division step for both the hue and saturation quotients.
`default_nettype none
module rhc_div_stage #(
    parameter int W   = 16,
    parameter int BIT = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       valid_in,
    input  wire logic [W-1:0]               range_in,
    input  wire logic [W-1:0]               mx_in,
    input  wire logic [W+16:0]              hue_rem_in,
    input  wire logic [W+16:0]              sat_rem_in,
    input  wire logic [rhc_pkg::QUOT_BITS-1:0] hue_quot_in,
    input  wire logic [rhc_pkg::QUOT_BITS-1:0] sat_quot_in,
    input  wire rhc_pkg::side_t             side_in,
    output logic                            valid_out,
    output logic [W-1:0]                    range_out,
    output logic [W-1:0]                    mx_out,
    output logic [W+16:0]                   hue_rem_out,
    output logic [W+16:0]                   sat_rem_out,
    output logic [rhc_pkg::QUOT_BITS-1:0]   hue_quot_out,
    output logic [rhc_pkg::QUOT_BITS-1:0]   sat_quot_out,
    output rhc_pkg::side_t                  side_out
);
    localparam int DW = W + 17;
    localparam logic [rhc_pkg::QUOT_BITS-1:0] QBIT = rhc_pkg::QUOT_BITS'(1) << BIT;

    logic [DW-1:0] hue_div, sat_div;
    logic          hue_ge, sat_ge;

    assign hue_div = DW'(range_in) << BIT;
    assign sat_div = DW'(mx_in) << BIT;
    assign hue_ge  = (hue_rem_in >= hue_div);
    assign sat_ge  = (sat_rem_in >= sat_div);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            range_out    <= range_in;
            mx_out       <= mx_in;
            side_out     <= side_in;
            hue_rem_out  <= hue_ge ? hue_rem_in - hue_div : hue_rem_in;
            sat_rem_out  <= sat_ge ? sat_rem_in - sat_div : sat_rem_in;
            hue_quot_out <= hue_ge ? (hue_quot_in | QBIT) : hue_quot_in;
            sat_quot_out <= sat_ge ? (sat_quot_in | QBIT) : sat_quot_in;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/rhc_back.sv =====
// Back end: hue offset and wrap, saturation clamp, output register.
`default_nettype none
module rhc_back #(
    parameter int W = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          valid_in,
    input  wire logic [W-1:0]                  mx_in,
    input  wire logic [rhc_pkg::QUOT_BITS-1:0] hue_quot,
    input  wire logic [rhc_pkg::QUOT_BITS-1:0] sat_quot,
    input  wire rhc_pkg::side_t                side_in,
    output logic                               valid_out,
    output logic [15:0]                        hue,
    output logic [15:0]                        saturation,
    output logic [15:0]                        value,
    output logic [15:0]                        alpha_out
);
    logic [15:0] q, hue_next, sat_next;

    assign q = hue_quot[15:0];

    always_comb
    begin
        case (side_in.hcase)
            rhc_pkg::HUE_RED:
                hue_next = (side_in.neg && q != '0) ? rhc_pkg::DEG360 - q : q;
            rhc_pkg::HUE_GREEN:
                hue_next = side_in.neg ? rhc_pkg::DEG120 - q : rhc_pkg::DEG120 + q;
            rhc_pkg::HUE_BLUE:
                hue_next = side_in.neg ? rhc_pkg::DEG240 - q : rhc_pkg::DEG240 + q;
            default:
                hue_next = '0;
        endcase
        if (side_in.grey)
            hue_next = '0;
        if (side_in.black)
            sat_next = '0;
        else if (sat_quot[16])
            sat_next = 16'hFFFF;
        else
            sat_next = sat_quot[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue        <= hue_next;
            saturation <= sat_next;
            value      <= 16'(mx_in);
            alpha_out  <= side_in.alpha;
        end
    end
endmodule
`default_nettype wire

// ===== tb/rgb_to_hsv_convert_tb.sv =====
// Self-checking testbench for the RGB to HSV converter.
`default_nettype none
module rgb_to_hsv_convert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] value;
        logic [15:0] alpha_out;
    } hsv_t;

    localparam int LATENCY    = 20;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 60;

    logic clk;
    logic rst_n;

    rhc_pixel_if pix_if ();
    rhc_hsv_if   hsv_if ();

    rgb_to_hsv_convert #(.CHANNEL_BITS(16)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_if.sink),
        .hsv_out (hsv_if.source)
    );

    pixel_t pending_pixels[$];
    hsv_t   expected_hsv[$];
    int     error_count;
    int     idle_cycles;
    bit     stim_done;
    bit     sender_paused;
    bit     hold_request;
    bit     in_fire;
    int     hold_left;
    int     send_wait;
    int     recv_wait;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Signed hue term scaled to U9.7: trunc((a - b) * 7680 / range)
    function automatic longint hue_part(longint a, longint b, longint range);
        if (a >= b)
            return ((a - b) * rhc_pkg::HUE_SCALE) / range;
        return -(((b - a) * rhc_pkg::HUE_SCALE) / range);
    endfunction

    function automatic hsv_t convert_pixel(pixel_t p);
        longint r, g, b, mx, mn, range, hue, sat;
        hsv_t   res;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        range = mx - mn;
        hue = 0;
        sat = 0;
        if (range != 0)
        begin
            if (mx == r)
            begin
                hue = hue_part(g, b, range);
                if (hue < 0)
                    hue += longint'(rhc_pkg::DEG360);
            end
            else if (mx == g)
                hue = hue_part(b, r, range) + longint'(rhc_pkg::DEG120);
            else
                hue = hue_part(r, g, range) + longint'(rhc_pkg::DEG240);
        end
        if (mx != 0)
        begin
            sat = (range << 16) / mx;
            if (sat > 65535)
                sat = 65535;
        end
        res.hue        = hue[15:0];
        res.saturation = sat[15:0];
        res.value      = mx[15:0];
        res.alpha_out  = p.alpha;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    task automatic add_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic [15:0] a);
        pending_pixels.push_back({r, g, b, a});
    endtask

    // Driver: advance on falling edge, hold valid until the transaction is taken
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_if.valid <= 1'b0;
            pix_if.red   <= '0;
            pix_if.green <= '0;
            pix_if.blue  <= '0;
            pix_if.alpha <= '0;
            send_wait    <= 0;
        end
        else if (pix_if.valid && !in_fire)
        begin
        end
        else if (send_wait > 0)
        begin
            pix_if.valid <= 1'b0;
            send_wait    <= send_wait - 1;
        end
        else if (pending_pixels.size() > 0 && !sender_paused)
        begin
            pixel_t p;
            p = pending_pixels.pop_front();
            pix_if.valid <= 1'b1;
            pix_if.red   <= p.red;
            pix_if.green <= p.green;
            pix_if.blue  <= p.blue;
            pix_if.alpha <= p.alpha;
            if (!hold_request)
                send_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0;
        end
        else
            pix_if.valid <= 1'b0;
    end

    // Predict at acceptance
    always @(posedge clk)
    begin
        in_fire <= rst_n && pix_if.valid && pix_if.ready;
        if (rst_n && pix_if.valid && pix_if.ready)
            expected_hsv.push_back(convert_pixel({pix_if.red, pix_if.green,
                                                  pix_if.blue, pix_if.alpha}));
    end

    // Receiver ready: random stalls plus one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_if.ready <= 1'b0;
            recv_wait    <= 0;
            hold_left    <= 0;
        end
        else if (hold_request && hold_left == 0 && hsv_if.ready)
        begin
            hold_left    <= HOLD_LEN;
            hsv_if.ready <= 1'b0;
        end
        else if (hold_left > 1)
            hold_left <= hold_left - 1;
        else if (hold_left == 1)
        begin
            hold_left    <= 0;
            hsv_if.ready <= 1'b1;
        end
        else if (recv_wait > 0)
        begin
            hsv_if.ready <= 1'b0;
            recv_wait    <= recv_wait - 1;
        end
        else
        begin
            hsv_if.ready <= 1'b1;
            if (hsv_if.valid && hsv_if.ready && $urandom_range(0, 3) == 0)
                recv_wait <= $urandom_range(0, 7);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && hsv_if.valid && hsv_if.ready)
        begin
            if (expected_hsv.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                error_count++;
            end
            else
            begin
                hsv_t want;
                want = expected_hsv.pop_front();
                if (hsv_if.hue !== want.hue)
                    report_mismatch("hue", hsv_if.hue, want.hue);
                if (hsv_if.saturation !== want.saturation)
                    report_mismatch("saturation", hsv_if.saturation, want.saturation);
                if (hsv_if.value !== want.value)
                    report_mismatch("value", hsv_if.value, want.value);
                if (hsv_if.alpha_out !== want.alpha_out)
                    report_mismatch("alpha_out", hsv_if.alpha_out, want.alpha_out);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (hsv_if.valid && hsv_if.ready))
            idle_cycles <= 0;
        else if (!stim_done || expected_hsv.size() > 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] r, g, b, m;
        error_count   = 0;
        idle_cycles   = 0;
        stim_done     = 1'b0;
        sender_paused = 1'b0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;

        // Directed: extremes, grey, black, full saturation, wraps, ties
        add_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_pixel(16'h1234, 16'h1234, 16'h1234, 16'hA5A5);
        add_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h5A5A);
        add_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0001);
        add_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
        add_pixel(16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
        add_pixel(16'hFFFF, 16'h0001, 16'h0000, 16'h0000);
        add_pixel(16'h8000, 16'h1000, 16'h7000, 16'h0000);
        add_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        add_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        add_pixel(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(16'h0000, 16'h0001, 16'h0002, 16'h0000);
        add_pixel(16'h0002, 16'h0001, 16'h0001, 16'h0000);
        add_pixel(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF);
        add_pixel(16'h4000, 16'h8000, 16'h2000, 16'h0000);
        add_pixel(16'h1000, 16'h2000, 16'h8000, 16'h0000);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_pixels.size() == 0);

        // Pause the sender until the pipeline drains
        sender_paused = 1'b1;
        wait (pix_if.valid == 1'b0 && expected_hsv.size() == 0);
        sender_paused = 1'b0;

        for (int i = 0; i < 700; i++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    r = 16'($urandom);
                    g = r;
                    b = r;
                end
                1:
                begin
                    m = 16'($urandom);
                    r = m;
                    g = 16'($urandom_range(0, m));
                    b = $urandom_range(0, 1) ? m : 16'($urandom_range(0, m));
                end
                2:
                begin
                    r = 16'($urandom_range(0, 15));
                    g = 16'($urandom_range(0, 15));
                    b = 16'($urandom_range(0, 15));
                end
                default:
                begin
                    r = 16'($urandom);
                    g = 16'($urandom);
                    b = 16'($urandom);
                end
            endcase
            add_pixel(r, g, b, 16'($urandom));
            if (i == 300)
            begin
                // Long receiver hold-off while the sender keeps offering
                hold_request = 1'b1;
                wait (hold_left != 0);
                hold_request = 1'b0;
            end
        end

        // Hold until the last transaction has been taken
        wait (pending_pixels.size() == 0);
        @(negedge clk);
        wait (!pix_if.valid);
        @(posedge clk);
        stim_done = 1'b1;
        wait (expected_hsv.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
